FILE: design/qcss_pkg.sv
// ----------------------------------------------------------------------------
// qcss_pkg
// Shared types and constants of the queued command slot scheduler.
// ----------------------------------------------------------------------------
package qcss_pkg;

  localparam int unsigned MaxSlotsDef = 32;
  localparam logic [7:0]  WaiterMax   = 8'd255;
  localparam logic [5:0]  SlotCountRst = 6'd32;

  typedef enum logic [1:0] {
    CMD_ISSUE    = 2'd0,
    CMD_WITHDRAW = 2'd1,
    CMD_POLL     = 2'd2,
    CMD_TIMEOUT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_GRANT  = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_DEAD   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IOERR   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_queued;
    logic [3:0]  link_pmp;
    logic [5:0]  link_depth;
    logic        already_waiting;
    logic [31:0] pending_mask;
    logic        error_seen;
    logic        restart_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] slot;
    logic [1:0] status;
    logic       now_waiting;
    logic [5:0] in_flight;
    logic [5:0] peak_in_flight;
    logic       last;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_queued;
    logic [3:0]  link_pmp;
    logic [5:0]  link_depth;
    logic        already_waiting;
    logic [31:0] done_mask;   // slots the sweep should consider
    logic [1:0]  status;
    logic        restart_ok;
  } work_t;

  localparam int unsigned RegAddrW = 1;
  localparam logic [RegAddrW-1:0] RegSlotCount = 1'b0;

endpackage

FILE: design/qcss_if.sv
// ----------------------------------------------------------------------------
// qcss_in_if / qcss_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface qcss_in_if;
  import qcss_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qcss_out_if;
  import qcss_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/qcss_front.sv
// ----------------------------------------------------------------------------
// qcss_front
// Accepts input items, classifies them and places them in a two-entry queue.
// ----------------------------------------------------------------------------
module qcss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  qcss_in_if.sink             in_if,
  output logic                wv_o,
  output qcss_pkg::work_t     work_o,
  input  logic                wr_i
);
  import qcss_pkg::*;

  work_t      q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  work_t      cls;
  logic       push, pop;

  // status is set here; the sweep mask is finalised in the back (busy slots known there)
  always_comb begin
    cls.cmd             = in_if.data.cmd;
    cls.is_queued       = in_if.data.is_queued;
    cls.link_pmp        = in_if.data.link_pmp;
    cls.link_depth      = in_if.data.link_depth;
    cls.already_waiting = in_if.data.already_waiting;
    cls.restart_ok      = in_if.data.restart_ok;
    cls.done_mask       = ~in_if.data.pending_mask;
    cls.status          = ST_OK;
    if (in_if.data.cmd == CMD_TIMEOUT) begin
      cls.done_mask = '1;
      cls.status    = ST_TIMEOUT;
    end else if (in_if.data.cmd == CMD_POLL && in_if.data.error_seen) begin
      cls.done_mask = '1;
      cls.status    = ST_IOERR;
    end
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign pop  = wv_o && wr_i;
  assign wv_o = (cnt_q != 2'd0);
  assign work_o = q_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: design/qcss_back.sv
// ----------------------------------------------------------------------------
// qcss_back
// Holds the slot state, decides issues and sweeps finished slots, at most one a cycle.
// ----------------------------------------------------------------------------
module qcss_back #(
  parameter int unsigned MAX_SLOTS = qcss_pkg::MaxSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [5:0]      slot_count_i,
  input  logic            wv_i,
  input  qcss_pkg::work_t work_i,
  output logic            wr_o,
  qcss_out_if.source      out_if
);
  import qcss_pkg::*;

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  bk_state_e   state_q, state_d;
  logic [MAX_SLOTS-1:0] busy_q, busy_d, qd_q, qd_d, sweep_q, sweep_d;
  logic        excl_q, excl_d, alv_q, alv_d, dead_q, dead_d;
  logic [3:0]  link_q, link_d;
  logic [7:0]  wait_q, wait_d;
  logic [5:0]  peak_q, peak_d, nbusy_q, nbusy_d, nq_q, nq_d;
  logic [1:0]  st_q, st_d;
  logic        fail_q, fail_d, rok_q, rok_d;
  logic [SW-1:0] sidx_q, sidx_d;
  out_item_t   ob_q, ob_d;
  logic        ov_q, ov_d;

  logic [5:0]  lim;
  logic        fr_found;
  logic [SW-1:0] fr_idx;
  logic [MAX_SLOTS-1:0] bit_m;
  logic        may, ob_free;

  assign lim = (slot_count_i > 6'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : slot_count_i;

  always_comb begin
    fr_found = 1'b0;
    fr_idx   = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (!busy_q[s] && 6'(s) < lim) begin
        fr_found = 1'b1;
        fr_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    may = 1'b1;
    if (excl_q) may = 1'b0;
    else if (busy_q != '0 && alv_q && link_q != work_i.link_pmp) may = 1'b0;
    else if (!work_i.is_queued) may = (busy_q == '0) && fr_found;
    else if (wait_q != 8'd0) may = 1'b0;
    else if (nq_q >= work_i.link_depth) may = 1'b0;
    else may = fr_found;
  end

  assign ob_free = !ov_q || out_if.ready;
  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;

  always_comb begin
    state_d = state_q;
    busy_d = busy_q; qd_d = qd_q; sweep_d = sweep_q;
    excl_d = excl_q; alv_d = alv_q; dead_d = dead_q;
    link_d = link_q; wait_d = wait_q; peak_d = peak_q;
    nbusy_d = nbusy_q; nq_d = nq_q;
    st_d = st_q; fail_d = fail_q; rok_d = rok_q; sidx_d = sidx_q;
    ob_d = ob_q; ov_d = ov_q && !out_if.ready;
    wr_o = 1'b0;
    bit_m = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (wv_i && ob_free) begin
          wr_o = 1'b1;
          ob_d = '0;
          ob_d.last = 1'b1;
          ob_d.peak_in_flight = peak_q;
          ob_d.in_flight = nbusy_q;
          unique case (work_i.cmd)
            CMD_ISSUE: begin
              ov_d = 1'b1;
              if (dead_q) begin
                if (work_i.already_waiting && wait_q != 8'd0) wait_d = wait_q - 8'd1;
                ob_d.kind = KIND_DEAD;
              end else if (may) begin
                bit_m = '0;
                bit_m[fr_idx] = 1'b1;
                if (work_i.already_waiting && wait_q != 8'd0) wait_d = wait_q - 8'd1;
                busy_d = busy_q | bit_m;
                if (work_i.is_queued) begin
                  qd_d = qd_q | bit_m;
                  nq_d = nq_q + 6'd1;
                end else begin
                  excl_d = 1'b1;
                end
                link_d = work_i.link_pmp;
                alv_d = 1'b1;
                nbusy_d = nbusy_q + 6'd1;
                if (nbusy_d > peak_q) peak_d = nbusy_d;
                ob_d.kind = KIND_GRANT;
                ob_d.slot = 5'(fr_idx);
                ob_d.in_flight = nbusy_d;
                ob_d.peak_in_flight = peak_d;
              end else begin
                ob_d.kind = KIND_REFUSE;
                ob_d.now_waiting = work_i.already_waiting;
                if (!work_i.is_queued && !work_i.already_waiting) begin
                  if (wait_q < WaiterMax) begin
                    wait_d = wait_q + 8'd1;
                    ob_d.now_waiting = 1'b1;
                  end else begin
                    ob_d.now_waiting = 1'b0;
                  end
                end
              end
            end
            CMD_WITHDRAW: begin
              ov_d = 1'b1;
              if (work_i.already_waiting && wait_q != 8'd0) wait_d = wait_q - 8'd1;
              ob_d.kind = KIND_REFUSE;
            end
            CMD_POLL, CMD_TIMEOUT: begin
              fail_d  = (work_i.cmd == CMD_TIMEOUT) || (work_i.status == ST_IOERR);
              rok_d   = work_i.restart_ok;
              st_d    = work_i.status;
              sweep_d = busy_q & work_i.done_mask[MAX_SLOTS-1:0];
              sidx_d  = '0;
              if (work_i.cmd == CMD_POLL && busy_q == '0) begin
                sweep_d = '0;
                fail_d  = 1'b0;
              end
              state_d = BK_RUN;
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        // one slot position per cycle, lowest first; a finishing slot waits on a full result register
        if (sweep_q == '0) begin
          if (fail_q) begin
            excl_d = 1'b0;
            if (!rok_q) dead_d = 1'b1;
          end
          state_d = BK_IDLE;
        end else if (!sweep_q[sidx_q]) begin
          sidx_d = sidx_q + SW'(1);
        end else if (ob_free) begin
          bit_m = '0;
          bit_m[sidx_q] = 1'b1;
          if (!qd_q[sidx_q]) excl_d = 1'b0;
          else nq_d = nq_q - 6'd1;
          busy_d  = busy_q & ~bit_m;
          qd_d    = qd_q & ~bit_m;
          sweep_d = sweep_q & ~bit_m;
          nbusy_d = nbusy_q - 6'd1;
          if (busy_d == '0) alv_d = 1'b0;
          ov_d = 1'b1;
          ob_d = '0;
          ob_d.kind = KIND_FINISH;
          ob_d.slot = 5'(sidx_q);
          ob_d.status = st_q;
          ob_d.in_flight = nbusy_d;
          ob_d.peak_in_flight = peak_q;
          ob_d.last = (sweep_d == '0);
          sidx_d = sidx_q + SW'(1);
        end
      end
      BK_HOLD: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      busy_q <= '0; qd_q <= '0; sweep_q <= '0;
      excl_q <= 1'b0; alv_q <= 1'b0; dead_q <= 1'b0;
      link_q <= '0; wait_q <= '0; peak_q <= '0;
      nbusy_q <= '0; nq_q <= '0;
      st_q <= '0; fail_q <= 1'b0; rok_q <= 1'b0; sidx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d; qd_q <= qd_d; sweep_q <= sweep_d;
      excl_q <= excl_d; alv_q <= alv_d; dead_q <= dead_d;
      link_q <= link_d; wait_q <= wait_d; peak_q <= peak_d;
      nbusy_q <= nbusy_d; nq_q <= nq_d;
      st_q <= st_d; fail_q <= fail_d; rok_q <= rok_d; sidx_q <= sidx_d;
      ov_q <= ov_d;
    end
  end
endmodule

FILE: design/queued_command_slot_scheduler.sv
// ----------------------------------------------------------------------------
// queued_command_slot_scheduler
// Command slot scheduler of one storage port.
// ----------------------------------------------------------------------------
// Input channel in_if carries issue, withdraw, poll and timeout commands;
// output channel out_if returns one result per issue or withdraw, and one
// result per finished slot for polls and timeouts, the final one with last.
// slot_count is written over the APB port at address 0.
// A front stage queues up to two commands; the back unit handles one at a
// time. An issue or withdraw result is registered when the back unit takes
// its command, and the back unit takes one of these a cycle while the result
// register is free. A poll or timeout holds the back unit through a decode
// step, a scan of slot positions from the lowest up to the highest slot it
// finishes (at most MAX_SLOTS positions) and a closing step.
// Reset clears every slot, the waiter count and the dead mark; slot_count
// returns to 32. When the receiver stalls the result register holds and the
// back unit waits; the front keeps taking commands until its queue fills.
// ----------------------------------------------------------------------------
module queued_command_slot_scheduler #(
  parameter int unsigned MAX_SLOTS = qcss_pkg::MaxSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qcss_in_if.sink     in_if,
  qcss_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qcss_pkg::*;

  logic [5:0] slot_count_q;
  logic       wv, wr;
  work_t      work;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {26'd0, slot_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      slot_count_q <= pwdata[5:0];
    end
  end

  qcss_front u_front (
    .clk_i, .rst_ni, .in_if, .wv_o(wv), .work_o(work), .wr_i(wr)
  );

  qcss_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk_i, .rst_ni, .slot_count_i(slot_count_q), .wv_i(wv), .work_i(work),
    .wr_o(wr), .out_if
  );
endmodule

FILE: design/qcss_checker.sv
// ----------------------------------------------------------------------------
// qcss_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module qcss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [4:0]  out_slot,
  input logic [1:0]  out_status,
  input logic        out_wait,
  input logic [5:0]  out_flight,
  input logic [5:0]  out_peak,
  input logic        out_last
);
  import qcss_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_slot))
    else $error("result changed under stall");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_flight <= out_peak)
    else $error("in flight above peak");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_FINISH |-> out_last)
    else $error("non-finish result not last");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_FINISH |-> out_status == ST_OK)
    else $error("status on non-finish result");

  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_REFUSE |-> !out_wait)
    else $error("waiting mark outside refusal");
endmodule

bind queued_command_slot_scheduler qcss_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_kind(out_if.data.kind), .out_slot(out_if.data.slot),
  .out_status(out_if.data.status), .out_wait(out_if.data.now_waiting),
  .out_flight(out_if.data.in_flight), .out_peak(out_if.data.peak_in_flight),
  .out_last(out_if.data.last)
);
